### hdl/cfp_pkg.sv
package cfp_pkg;

  // storage geometry
  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CAP_W  = 11;

  // configuration register map
  localparam logic [CAP_W-1:0] CAP_RESET    = CAP_W'(DEPTH);
  localparam logic             REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    CMD_PUSH      = 2'd0,
    CMD_POP       = 2'd1,
    CMD_OVERWRITE = 2'd2,
    CMD_READ      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // result fields other than the data word
  typedef struct packed {
    status_e            status;
    logic [CNT_W-1:0]   count;
    logic               full;
    logic               empty;
    logic               ovf;
    logic               unf;
  } meta_t;

  // one access per command on the slot memory
  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  wdata;
  } ram_req_t;

endpackage

### hdl/cfp_ram.sv
module cfp_ram (
  input  logic                      clk_i,
  input  cfp_pkg::ram_req_t         req_i,
  output logic [cfp_pkg::DATA_W-1:0] rdata_o
);
  import cfp_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/cfp_ctrl.sv
module cfp_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  cfp_pkg::cmd_e              cmd_i,
  input  logic [cfp_pkg::DATA_W-1:0] value_i,
  input  logic [cfp_pkg::IDX_W-1:0]  index_i,
  input  logic [cfp_pkg::CAP_W-1:0]  cap_reg_i,
  input  logic                       clear_i,
  output cfp_pkg::ram_req_t          ram_req_o,
  output cfp_pkg::meta_t             meta_o,
  output logic                       use_mem_o
);
  import cfp_pkg::*;

  logic [ADDR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic              ovf_q, ovf_d, unf_q, unf_d;

  logic [CNT_W-1:0]  cap_eff;
  logic              full_now;
  logic [ADDR_W-1:0] wp_next, rp_next, peek_addr;
  logic [CNT_W-1:0]  wp_inc, rp_inc, peek_sum;
  status_e           status;

  // clamp the capacity register to 1..DEPTH
  always_comb begin
    if (cap_reg_i == '0) begin
      cap_eff = CNT_W'(1);
    end else if (CNT_W'(cap_reg_i) > CNT_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_reg_i);
    end
  end

  // pointer advance with wrap at the capacity in use
  assign wp_inc   = {1'b0, wp_q} + CNT_W'(1);
  assign rp_inc   = {1'b0, rp_q} + CNT_W'(1);
  assign wp_next  = (wp_inc == cap_eff) ? '0 : wp_inc[ADDR_W-1:0];
  assign rp_next  = (rp_inc == cap_eff) ? '0 : rp_inc[ADDR_W-1:0];
  assign full_now = (held_q >= cap_eff);

  // peek position, sum stays below twice the capacity
  assign peek_sum  = {1'b0, rp_q} + CNT_W'(index_i);
  assign peek_addr = (peek_sum >= cap_eff) ? ADDR_W'(peek_sum - cap_eff)
                                           : peek_sum[ADDR_W-1:0];

  // command decode and state update
  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    held_d    = held_q;
    ovf_d     = ovf_q;
    unf_d     = unf_q;
    status    = ST_OK;
    use_mem_o = 1'b0;
    ram_req_o = '{wr_en: 1'b0, rd_en: 1'b0, addr: wp_q, wdata: value_i};
    case (cmd_i)
      CMD_PUSH: begin
        if (full_now) begin
          ovf_d  = 1'b1;
          status = ST_FULL;
        end else begin
          ram_req_o.wr_en = 1'b1;
          held_d          = held_q + CNT_W'(1);
          wp_d            = wp_next;
          unf_d           = 1'b0;
        end
      end
      CMD_POP: begin
        if (held_q == '0) begin
          unf_d  = 1'b1;
          status = ST_EMPTY;
        end else begin
          ram_req_o.rd_en = 1'b1;
          ram_req_o.addr  = rp_q;
          use_mem_o       = 1'b1;
          held_d          = held_q - CNT_W'(1);
          rp_d            = rp_next;
          ovf_d           = 1'b0;
        end
      end
      CMD_OVERWRITE: begin
        // drop the oldest entry when full, count stays
        ram_req_o.wr_en = 1'b1;
        wp_d            = wp_next;
        unf_d           = 1'b0;
        if (full_now) begin
          rp_d  = rp_next;
          ovf_d = 1'b0;
        end else begin
          held_d = held_q + CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (CNT_W'(index_i) >= held_q) begin
          status = ST_RANGE;
        end else begin
          ram_req_o.rd_en = 1'b1;
          ram_req_o.addr  = peek_addr;
          use_mem_o       = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
    if (!req_valid_i) begin
      ram_req_o.wr_en = 1'b0;
      ram_req_o.rd_en = 1'b0;
    end
  end

  // status fields after the command
  assign meta_o = '{status: status, count: held_d, full: (held_d == cap_eff),
                    empty: (held_d == '0), ovf: ovf_d, unf: unf_d};

  // queue state, emptied on a capacity write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      held_q <= '0;
      ovf_q  <= 1'b0;
      unf_q  <= 1'b0;
    end else if (clear_i) begin
      wp_q   <= '0;
      rp_q   <= '0;
      held_q <= '0;
    end else if (req_valid_i) begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      held_q <= held_d;
      ovf_q  <= ovf_d;
      unf_q  <= unf_d;
    end
  end

  // count never exceeds the capacity in use
  a_held_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= cap_eff) else $error("entry count above capacity");

  // pointers stay inside the ring
  a_ptr_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, wp_q} < cap_eff) && ({1'b0, rp_q} < cap_eff))
    else $error("pointer outside the ring");

  // a successful pop lowers the count by one
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && !clear_i && cmd_i == CMD_POP && held_q != '0)
    |=> held_q == $past(held_q) - CNT_W'(1)) else $error("pop count slip");

  // overwrite on full clears both sticky flags and keeps the count
  a_ovw_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && !clear_i && cmd_i == CMD_OVERWRITE && full_now)
    |=> !ovf_q && !unf_q && held_q == $past(held_q))
    else $error("overwrite on full slip");

endmodule

### hdl/circular_fifo_with_peek.sv
// Ring-buffer queue of 32-bit words with a peek command.
// Request channel (s_axis_*): tuser carries the command (push, pop,
// overwrite push, read at index), tdata the value and the index. Every
// request gives exactly one result on m_axis_*: the popped or peeked
// word, the status code in tuser, then count, full, empty and the two
// sticky flags in tdata.
// Path: a taken request passes the slot memory read, registered with the
// read stage, and then the output register.
// Throughput: one request per cycle; the single port of the slot memory
// carries one access per request, and the queue state updates at accept.
// A result that waits in the output register stalls at most one more
// request, which is held behind it; then s_axis_tready drops until the
// receiver takes the result.
// The APB port holds the capacity in use (byte address 0); writing it
// empties the queue and keeps the flags. Write it only while idle.
// Reset: pointers, count and flags clear, capacity becomes 1024; the
// slot memory is not cleared since an entry is never read before written.
module circular_fifo_with_peek (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // value[31:0], index[41:32], zero pad
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // data[31:0], entry_count[42:32], is_full[43],
                                     // is_empty[44], overflow_seen[45],
                                     // underflow_seen[46], zero pad
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfp_pkg::*;

  logic [CAP_W-1:0]  cap_q;
  logic              cfg_wr;
  logic              accept;
  ram_req_t          ram_req;
  meta_t             meta;
  logic              use_mem;
  logic [DATA_W-1:0] rdata;

  logic              s1_valid_q, s1_mem_q;
  meta_t             s1_meta_q;
  logic              out_valid_q;
  meta_t             out_meta_q;
  logic [DATA_W-1:0] out_data_q;
  logic              s1_move;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // handshake: read stage moves on when the output register frees
  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (accept),
    .cmd_i       (cmd_e'(s_axis_tuser)),
    .value_i     (s_axis_tdata[DATA_W-1:0]),
    .index_i     (s_axis_tdata[DATA_W+IDX_W-1:DATA_W]),
    .cap_reg_i   (cap_q),
    .clear_i     (cfg_wr),
    .ram_req_o   (ram_req),
    .meta_o      (meta),
    .use_mem_o   (use_mem)
  );

  cfp_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  // memory read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  // memory read stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta;
      s1_mem_q  <= use_mem;
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_meta_q <= s1_meta_q;
      out_data_q <= s1_mem_q ? rdata : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_meta_q.status;
  assign m_axis_tdata  = {1'b0, out_meta_q.unf, out_meta_q.ovf, out_meta_q.empty,
                          out_meta_q.full, out_meta_q.count, out_data_q};

endmodule
